// File: rtl/nlp_pkg.sv
// Shared types, character codes and helper functions for the numeric literal parser.
// No dependencies; every other file of the block imports this package.
package nlp_pkg;

    // Character codes that the parser recognizes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LO_O  = 8'h6F;
    localparam logic [7:0] CH_UP_O  = 8'h4F;
    localparam logic [7:0] CH_LO_D  = 8'h64;
    localparam logic [7:0] CH_UP_D  = 8'h44;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_I  = 8'h69;
    localparam logic [7:0] CH_LO_U  = 8'h75;
    localparam logic [7:0] CH_LO_F  = 8'h66;

    // Width of the value field.
    localparam int unsigned VALUE_W = 64;

    // Number of body characters held back for the suffix check.
    localparam int unsigned PEND_DEPTH = 3;

    // Radix of the literal body.
    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    // Position of the current character within the literal.
    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_LATER  = 2'd2
    } pos_t;

    // Resolved type of the literal.
    typedef enum logic [3:0] {
        TY_I8  = 4'd0,
        TY_I16 = 4'd1,
        TY_I32 = 4'd2,
        TY_I64 = 4'd3,
        TY_U8  = 4'd4,
        TY_U16 = 4'd5,
        TY_U32 = 4'd6,
        TY_U64 = 4'd7,
        TY_F32 = 4'd8,
        TY_F64 = 4'd9
    } type_code_t;

    // Result status.
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_PREFIX = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_SUFFIX = 3'd3,
        ST_DIGIT  = 3'd4,
        ST_FLOAT  = 3'd5
    } status_t;

    // Snapshot of the parse state taken on the final character of a literal.
    typedef struct packed {
        logic [PEND_DEPTH-1:0][7:0] pend;
        logic [1:0]                 cnt;
        radix_t                     radix;
        logic [VALUE_W-1:0]         acc;
        logic                       err_prefix;
        logic                       err_digit;
        logic                       dot;
    } fin_t;

    // Digit value of a character, 16 when it is no hex digit at all.
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h41 + 8'd10);
        return d;
    endfunction

    // Numeric radix for the digit range check.
    function automatic logic [4:0] radix_limit(input radix_t r);
        logic [4:0] lim;
        case (r)
            RADIX_OCT: lim = 5'd8;
            RADIX_HEX: lim = 5'd16;
            default:   lim = 5'd10;
        endcase
        return lim;
    endfunction

    // Multiply the accumulator by the radix with shifts, and one add for decimal.
    function automatic logic [VALUE_W-1:0] times_radix(input logic [VALUE_W-1:0] a,
                                                       input radix_t r);
        logic [VALUE_W-1:0] p;
        case (r)
            RADIX_OCT: p = a << 3;
            RADIX_HEX: p = a << 4;
            default:   p = (a << 3) + (a << 1);
        endcase
        return p;
    endfunction

endpackage

// File: rtl/numeric_literal_parser_unit.sv
// Top level of the numeric literal parser: character intake, parse state and result register.
// Depends on nlp_pkg and nlp_finish.
//
// The block takes one character item per cycle while input ready is high, and gives one
// result item for each literal via the finish and result registers. A character enters the
// parse state in the cycle it is accepted; the final character also moves a snapshot of that
// state into a finish register and clears the state, so the next literal can start at once. The
// finish stage resolves the suffix, commits the held-back digits and masks the value into the
// result register. The sustained rate is one character per cycle; input ready drops only when a
// finished literal waits in the finish register behind a result that is not taken.
module numeric_literal_parser_unit
    import nlp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_code,
    input  logic               last_char,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] value_bits,
    output logic [3:0]         type_code,
    output logic [2:0]         status
);

    pos_t                       pos_reg,    pos_next;
    logic [7:0]                 first_reg,  first_next;
    logic [PEND_DEPTH-1:0][7:0] pend_reg,   pend_next;
    logic [1:0]                 cnt_reg,    cnt_next;
    radix_t                     radix_reg,  radix_next;
    logic [VALUE_W-1:0]         acc_reg,    acc_next;
    logic                       errp_reg,   errp_next;
    logic                       errd_reg,   errd_next;
    logic                       dot_reg,    dot_next;

    fin_t                       fin_reg;
    logic                       fin_valid_reg;
    logic                       out_valid_reg;
    logic [VALUE_W-1:0]         value_reg;
    type_code_t                 type_reg;
    status_t                    status_reg;

    logic                       in_fire;
    logic                       advance;
    logic                       is_prefix;
    logic [4:0]                 d_raw;
    logic                       d_bad;
    fin_t                       snap;
    logic [VALUE_W-1:0]         res_value;
    type_code_t                 res_type;
    status_t                    res_status;

    // Handshake: the finish register frees up when its result moves on.
    assign advance  = fin_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !fin_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign is_prefix = (char_code == CH_LO_O) || (char_code == CH_UP_O) ||
                       (char_code == CH_LO_D) || (char_code == CH_UP_D) ||
                       (char_code == CH_LO_X) || (char_code == CH_UP_X);

    // Digit check for the oldest held-back character when it is committed.
    assign d_raw = digit_of(pend_reg[0]);
    assign d_bad = (d_raw >= radix_limit(radix_reg));

    // Next parse state for the accepted character.
    always_comb
    begin
        pos_next   = pos_reg;
        first_next = first_reg;
        pend_next  = pend_reg;
        cnt_next   = cnt_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        errp_next  = errp_reg;
        errd_next  = errd_reg;
        dot_next   = dot_reg;
        if (in_fire)
        begin
            dot_next = dot_reg | (char_code == CH_DOT);
            unique case (pos_reg)
                POS_FIRST:
                begin
                    first_next = char_code;
                    pos_next   = POS_SECOND;
                    if (last_char)
                    begin
                        pend_next[0] = char_code;
                        cnt_next     = 2'd1;
                    end
                end
                POS_SECOND:
                begin
                    pos_next = POS_LATER;
                    if (is_prefix)
                    begin
                        if (char_code == CH_LO_O || char_code == CH_UP_O)
                            radix_next = RADIX_OCT;
                        else if (char_code == CH_LO_X || char_code == CH_UP_X)
                            radix_next = RADIX_HEX;
                        else
                            radix_next = RADIX_DEC;
                        if (first_reg != CH_ZERO)
                            errp_next = 1'b1;
                    end
                    else
                    begin
                        pend_next[0] = first_reg;
                        pend_next[1] = char_code;
                        cnt_next     = 2'd2;
                    end
                end
                default:
                begin
                    if (cnt_reg == 2'd3)
                    begin
                        acc_next = times_radix(acc_reg, radix_reg) +
                                   (d_bad ? {VALUE_W{1'b0}}
                                          : {{(VALUE_W-4){1'b0}}, d_raw[3:0]});
                        errd_next    = errd_reg | d_bad;
                        pend_next[0] = pend_reg[1];
                        pend_next[1] = pend_reg[2];
                        pend_next[2] = char_code;
                    end
                    else
                    begin
                        pend_next[cnt_reg] = char_code;
                        cnt_next           = cnt_reg + 2'd1;
                    end
                end
            endcase
        end
    end

    // Snapshot of the state after the final character.
    always_comb
    begin
        snap.pend       = pend_next;
        snap.cnt        = cnt_next;
        snap.radix      = radix_next;
        snap.acc        = acc_next;
        snap.err_prefix = errp_next;
        snap.err_digit  = errd_next;
        snap.dot        = dot_next;
    end

    // Parse state registers, cleared after each literal.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_FIRST;
            first_reg <= '0;
            pend_reg  <= '0;
            cnt_reg   <= '0;
            radix_reg <= RADIX_DEC;
            acc_reg   <= '0;
            errp_reg  <= 1'b0;
            errd_reg  <= 1'b0;
            dot_reg   <= 1'b0;
        end
        else if (in_fire && last_char)
        begin
            pos_reg   <= POS_FIRST;
            first_reg <= '0;
            pend_reg  <= '0;
            cnt_reg   <= '0;
            radix_reg <= RADIX_DEC;
            acc_reg   <= '0;
            errp_reg  <= 1'b0;
            errd_reg  <= 1'b0;
            dot_reg   <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            first_reg <= first_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            radix_reg <= radix_next;
            acc_reg   <= acc_next;
            errp_reg  <= errp_next;
            errd_reg  <= errd_next;
            dot_reg   <= dot_next;
        end
    end

    // Valid flags of the finish and result stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire && last_char)
                fin_valid_reg <= 1'b1;
            else if (advance)
                fin_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload of the finish and result stages.
    always_ff @(posedge clk)
    begin
        if (in_fire && last_char)
            fin_reg <= snap;
        if (advance)
        begin
            value_reg  <= res_value;
            type_reg   <= res_type;
            status_reg <= res_status;
        end
    end

    nlp_finish u_finish (
        .fin        (fin_reg),
        .res_value  (res_value),
        .res_type   (res_type),
        .res_status (res_status)
    );

    assign out_valid  = out_valid_reg;
    assign value_bits = value_reg;
    assign type_code  = type_reg;
    assign status     = status_reg;

endmodule

// File: rtl/nlp_finish.sv
// Result computation for one completed literal: suffix decode, the last digit commits,
// status priority and width masking. Depends on nlp_pkg.
module nlp_finish
    import nlp_pkg::*;
(
    input  fin_t               fin,
    output logic [VALUE_W-1:0] res_value,
    output type_code_t         res_type,
    output status_t            res_status
);

    // Narrow multiply by the radix for the held-back digits.
    function automatic logic [11:0] small_times(input logic [11:0] x, input radix_t r);
        logic [11:0] p;
        case (r)
            RADIX_OCT: p = x << 3;
            RADIX_HEX: p = x << 4;
            default:   p = (x << 3) + (x << 1);
        endcase
        return p;
    endfunction

    // Accumulator times radix to the power of the number of committed digits.
    function automatic logic [VALUE_W-1:0] scale_acc(input logic [VALUE_W-1:0] a,
                                                     input radix_t r,
                                                     input logic [1:0] k);
        logic [VALUE_W-1:0] p;
        p = a;
        case (r)
            RADIX_OCT: p = a << (3 * k);
            RADIX_HEX: p = a << (4 * k);
            default:
            begin
                case (k)
                    2'd0: p = a;
                    2'd1: p = (a << 3) + (a << 1);
                    2'd2: p = (a << 6) + (a << 5) + (a << 2);
                    default: p = (a << 10) - (a << 4) - (a << 3);
                endcase
            end
        endcase
        return p;
    endfunction

    logic [4:0]            lim;
    logic [4:0]            d_raw [PEND_DEPTH];
    logic                  bad   [PEND_DEPTH];
    logic [11:0]           dg    [PEND_DEPTH];
    logic [7:0]            pp;
    logic [7:0]            pn;
    logic [7:0]            la;
    type_code_t            def_type;
    type_code_t            ty;
    status_t               st;
    logic [1:0]            keep;
    logic                  any_bad;
    logic [11:0]           dsum;
    logic [VALUE_W-1:0]    scaled;
    logic [VALUE_W-1:0]    total;
    logic [VALUE_W-1:0]    val;

    // Range check of each held-back character against the radix.
    assign lim = radix_limit(fin.radix);
    always_comb
    begin
        for (int i = 0; i < PEND_DEPTH; i++)
        begin
            d_raw[i] = digit_of(fin.pend[i]);
            bad[i]   = (d_raw[i] >= lim);
            dg[i]    = bad[i] ? 12'd0 : {8'd0, d_raw[i][3:0]};
        end
    end

    assign pp = fin.pend[0];
    assign pn = fin.pend[1];
    assign la = fin.pend[2];

    // Suffix decode and status priority.
    always_comb
    begin
        def_type = fin.dot ? TY_F32 : TY_I32;
        ty       = def_type;
        st       = ST_OK;
        keep     = fin.cnt;
        if (fin.err_prefix)
        begin
            st = ST_PREFIX;
        end
        else if (fin.cnt == 2'd0)
        begin
            st = ST_EMPTY;
        end
        else if (fin.cnt == 2'd3)
        begin
            if (pn == CH_LO_I || pn == CH_LO_U)
            begin
                if (la == CH_EIGHT)
                begin
                    ty   = (pn == CH_LO_I) ? TY_I8 : TY_U8;
                    keep = 2'd1;
                end
                else
                begin
                    st = ST_SUFFIX;
                end
            end
            else if (pn == CH_ONE && la == CH_SIX && (pp == CH_LO_I || pp == CH_LO_U))
            begin
                ty   = (pp == CH_LO_I) ? TY_I16 : TY_U16;
                keep = 2'd0;
            end
            else if (pn == CH_THREE && la == CH_TWO &&
                     (pp == CH_LO_I || pp == CH_LO_U || pp == CH_LO_F))
            begin
                ty   = (pp == CH_LO_I) ? TY_I32 : (pp == CH_LO_U) ? TY_U32 : TY_F32;
                keep = 2'd0;
            end
            else if (pn == CH_SIX && la == CH_FOUR &&
                     (pp == CH_LO_I || pp == CH_LO_U || pp == CH_LO_F))
            begin
                ty   = (pp == CH_LO_I) ? TY_I64 : (pp == CH_LO_U) ? TY_U64 : TY_F64;
                keep = 2'd0;
            end
        end
    end

    // Commit the kept digits: scaled accumulator plus a narrow digit sum.
    always_comb
    begin
        any_bad = fin.err_digit;
        dsum    = 12'd0;
        case (keep)
            2'd0: dsum = 12'd0;
            2'd1:
            begin
                any_bad = any_bad | bad[0];
                dsum    = dg[0];
            end
            2'd2:
            begin
                any_bad = any_bad | bad[0] | bad[1];
                dsum    = small_times(dg[0], fin.radix) + dg[1];
            end
            default:
            begin
                any_bad = any_bad | bad[0] | bad[1] | bad[2];
                dsum    = small_times(small_times(dg[0], fin.radix) + dg[1], fin.radix)
                          + dg[2];
            end
        endcase
    end

    assign scaled = scale_acc(fin.acc, fin.radix, keep);
    assign total  = scaled + {{(VALUE_W-12){1'b0}}, dsum};

    // Final status, type and masked value.
    always_comb
    begin
        val        = '0;
        res_type   = ty;
        res_status = st;
        if (st == ST_OK)
        begin
            if (ty == TY_F32 || ty == TY_F64)
            begin
                res_status = ST_FLOAT;
            end
            else if (any_bad)
            begin
                res_status = ST_DIGIT;
            end
            else
            begin
                case (ty[1:0])
                    2'd0:    val = {{(VALUE_W-8){1'b0}},  total[7:0]};
                    2'd1:    val = {{(VALUE_W-16){1'b0}}, total[15:0]};
                    2'd2:    val = {{(VALUE_W-32){1'b0}}, total[31:0]};
                    default: val = total;
                endcase
            end
        end
        else
        begin
            res_type = def_type;
        end
    end

    assign res_value = val;

endmodule

// File: rtl/nlp_checker.sv
// Port-level checks for the numeric literal parser and the bind that attaches them.
// Depends on nlp_pkg and numeric_literal_parser_unit.
module nlp_checker
    import nlp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [7:0]         char_code,
    input logic               last_char,
    input logic               out_valid,
    input logic               out_ready,
    input logic [VALUE_W-1:0] value_bits,
    input logic [3:0]         type_code,
    input logic [2:0]         status
);

    // A stalled input item stays offered with the same character.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(char_code) && $stable(last_char))
    else $error("input item changed while stalled");

    // A stalled result item holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_bits) &&
                                    $stable(type_code) && $stable(status))
    else $error("result item changed while stalled");

    // Any failing status carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> value_bits == '0)
    else $error("error result with nonzero value");

    // An ok value fits the width of its type.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |->
            ((type_code[1:0] == 2'd0 && value_bits[VALUE_W-1:8] == '0) ||
             (type_code[1:0] == 2'd1 && value_bits[VALUE_W-1:16] == '0) ||
             (type_code[1:0] == 2'd2 && value_bits[VALUE_W-1:32] == '0) ||
             (type_code[1:0] == 2'd3)))
    else $error("ok value wider than its type");

    // Prefix, empty and suffix errors report the default type; float status a float type.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_PREFIX || status == ST_EMPTY || status == ST_SUFFIX ||
                      status == ST_FLOAT) |->
            (type_code == TY_I32 || type_code == TY_F32 ||
             (status == ST_FLOAT && type_code == TY_F64)))
    else $error("type code inconsistent with status");

endmodule

bind numeric_literal_parser_unit nlp_checker u_nlp_checker (.*);
